[sv/tfp_pkg.sv]
// shared types, codes and helpers for the two-channel fast pwm timer
package tfp_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int VALUE_W           = 16;
    localparam int PRESCALE_W        = 10;
    localparam int PWM10_TOP         = 1023;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_WR_CMP_A  = 3'd1,
        OP_WR_CMP_B  = 3'd2,
        OP_WR_COUNT  = 3'd3,
        OP_CLR_FLAGS = 3'd4
    } t_op;

    localparam logic [1:0] MODE_NORMAL    = 2'd0;
    localparam logic [1:0] MODE_PWM_10BIT = 2'd1;
    localparam logic [1:0] MODE_PWM_TOP   = 2'd2;

    localparam logic [1:0] CFG_TIMER_MODE     = 2'd0;
    localparam logic [1:0] CFG_CLOCK_SELECT   = 2'd1;
    localparam logic [1:0] CFG_TOP_VALUE      = 2'd2;
    localparam logic [1:0] CFG_CHANNEL_ENABLE = 2'd3;

    localparam logic [2:0] CLK_DIV1    = 3'd1;
    localparam logic [2:0] CLK_DIV8    = 3'd2;
    localparam logic [2:0] CLK_DIV64   = 3'd3;
    localparam logic [2:0] CLK_DIV256  = 3'd4;
    localparam logic [2:0] CLK_DIV1024 = 3'd5;

    localparam int FLAG_A   = 0;
    localparam int FLAG_B   = 1;
    localparam int FLAG_OVF = 2;

    typedef struct packed {
        logic advance;
        logic wr_cmp_a;
        logic wr_cmp_b;
        logic wr_count;
        logic clr_flags;
    } t_ctrl;

    typedef struct packed {
        logic                 flag_overflow;
        logic                 flag_match_b;
        logic                 flag_match_a;
        logic                 pwm_out_b;
        logic                 pwm_out_a;
        logic [VALUE_W-1:0]   counter_now;
    } t_result;

    // zero means the prescaler is stopped
    function automatic logic [PRESCALE_W:0] divisor_of(input logic [2:0] sel);
        logic [PRESCALE_W:0] div;
        case (sel)
            CLK_DIV1:    div = 11'd1;
            CLK_DIV8:    div = 11'd8;
            CLK_DIV64:   div = 11'd64;
            CLK_DIV256:  div = 11'd256;
            CLK_DIV1024: div = 11'd1024;
            default:     div = 11'd0;
        endcase
        return div;
    endfunction

endpackage

[sv/timer_fast_pwm_two_channel.sv]
// top level of the two-channel fast pwm timer: stream ports, config, pipeline registers
// Each transfer (a tick or a register write) is held in an input register until the output side
// is free; then the prescaler and counter logic update the timer state and load the result register
// from it; one result follows every transfer. A new transfer is taken every cycle while
// the output side accepts; while a result waits on the output, one more transfer is taken
// into the input register and then the input stalls until the result leaves. Configuration
// writes take effect at once and should be done while no transfer is in flight.
module timer_fast_pwm_two_channel
    import tfp_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [2:0] operation, [18:3] value, [23:19] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] counter_now, [16] pwm_out_a, [17] pwm_out_b, [18] flag_match_a,
    // [19] flag_match_b, [20] flag_overflow, [23:21] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [1:0]         r_timer_mode;
    logic [2:0]         r_clock_select;
    logic [VALUE_W-1:0] r_top_value;
    logic [1:0]         r_channel_enable;

    logic               r_in_valid;
    logic [2:0]         r_op;
    logic [VALUE_W-1:0] r_value;
    logic               r_out_valid;
    t_result            r_result;

    logic    out_free;
    logic    proc;
    logic    advance;
    t_ctrl   ctrl;
    t_result result;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_comb begin
        ctrl.advance   = advance;
        ctrl.wr_cmp_a  = proc && (r_op == OP_WR_CMP_A);
        ctrl.wr_cmp_b  = proc && (r_op == OP_WR_CMP_B);
        ctrl.wr_count  = proc && (r_op == OP_WR_COUNT);
        ctrl.clr_flags = proc && (r_op == OP_CLR_FLAGS);
    end

    tfp_prescaler u_prescaler (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (proc && (r_op == OP_TICK)),
        .i_clock_select (r_clock_select),
        .o_advance      (advance)
    );

    tfp_core #(
        .CW (COUNTER_WIDTH)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .i_value          (r_value),
        .i_timer_mode     (r_timer_mode),
        .i_top_value      (r_top_value),
        .i_channel_enable (r_channel_enable),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_mode     <= '0;
            r_clock_select   <= '0;
            r_top_value      <= '0;
            r_channel_enable <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TIMER_MODE:     r_timer_mode     <= i_cfg_data[1:0];
                CFG_CLOCK_SELECT:   r_clock_select   <= i_cfg_data[2:0];
                CFG_TOP_VALUE:      r_top_value      <= i_cfg_data;
                CFG_CHANNEL_ENABLE: r_channel_enable <= i_cfg_data[1:0];
                default:            r_timer_mode     <= r_timer_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op    <= s_axis_tdata[2:0];
            r_value <= s_axis_tdata[18:3];
        end
        if (proc) begin
            r_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - $bits(t_result)){1'b0}}, r_result};

    // the input side is blocked only while an item is held and the output is stalled
    a_ready_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a held item and a stalled result");

    // a counter write shows up as the reported count
    a_count_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && (r_op == OP_WR_COUNT)) |=>
        (m_axis_tdata[15:0] == VALUE_W'(COUNTER_WIDTH'($past(r_value)))))
        else $error("counter write not reflected in result");

    // clearing the overflow flag wins over everything else in that item
    a_clear_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && (r_op == OP_CLR_FLAGS) && r_value[FLAG_OVF]) |=> !m_axis_tdata[20])
        else $error("overflow flag not cleared");

    // each processed item loads exactly one result
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> m_axis_tvalid)
        else $error("processed item produced no result");

endmodule

[sv/tfp_prescaler.sv]
// clock prescaler: turns tick transfers into counter advance pulses
module tfp_prescaler
    import tfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  logic [2:0] i_clock_select,
    output logic       o_advance
);

    logic [PRESCALE_W-1:0] r_prescale;
    logic [PRESCALE_W-1:0] n_prescale;
    logic [PRESCALE_W:0]   div;
    logic [PRESCALE_W:0]   inc;

    always_comb begin
        div        = divisor_of(i_clock_select);
        inc        = {1'b0, r_prescale} + {{PRESCALE_W{1'b0}}, 1'b1};
        n_prescale = r_prescale;
        o_advance  = 1'b0;
        if (i_tick && (div != '0)) begin
            if (inc >= div) begin
                n_prescale = '0;
                o_advance  = 1'b1;
            end else begin
                n_prescale = inc[PRESCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
        end else begin
            r_prescale <= n_prescale;
        end
    end

endmodule

[sv/tfp_core.sv]
// counter, compare channels, sticky flags and output levels
module tfp_core
    import tfp_pkg::*;
#(
    parameter int CW = COUNTER_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl              i_ctrl,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [1:0]         i_timer_mode,
    input  logic [VALUE_W-1:0] i_top_value,
    input  logic [1:0]         i_channel_enable,
    output t_result            o_result
);

    logic [CW-1:0] r_count,  n_count;
    logic [CW-1:0] r_cmp_a,  n_cmp_a;
    logic [CW-1:0] r_cmp_b,  n_cmp_b;
    logic [CW-1:0] r_pend_a, n_pend_a;
    logic [CW-1:0] r_pend_b, n_pend_b;
    logic [2:0]    r_flags,  n_flags;
    logic [1:0]    r_levels, n_levels;

    logic          pwm_mode;
    logic [CW-1:0] top;
    logic [CW-1:0] val_cw;
    logic [1:0]    gated;

    always_comb begin
        pwm_mode = (i_timer_mode == MODE_PWM_10BIT) || (i_timer_mode == MODE_PWM_TOP);
        case (i_timer_mode)
            MODE_PWM_10BIT: top = CW'(PWM10_TOP);
            MODE_PWM_TOP:   top = CW'(i_top_value);
            default:        top = '1;
        endcase
        val_cw = CW'(i_value);

        n_count  = r_count;
        n_cmp_a  = r_cmp_a;
        n_cmp_b  = r_cmp_b;
        n_pend_a = r_pend_a;
        n_pend_b = r_pend_b;
        n_flags  = r_flags;
        n_levels = r_levels;

        if (i_ctrl.advance) begin
            if ((r_count == top) || (r_count == '1)) begin
                n_count           = '0;
                n_flags[FLAG_OVF] = 1'b1;
                n_levels          = 2'b11;
                if (pwm_mode) begin
                    n_cmp_a = r_pend_a;
                    n_cmp_b = r_pend_b;
                end
            end else begin
                n_count = r_count + 1'b1;
            end
            if (n_count == n_cmp_a) begin
                n_flags[FLAG_A] = 1'b1;
                n_levels[0]     = 1'b0;
            end
            if (n_count == n_cmp_b) begin
                n_flags[FLAG_B] = 1'b1;
                n_levels[1]     = 1'b0;
            end
        end
        if (i_ctrl.wr_cmp_a) begin
            n_pend_a = val_cw;
            if (!pwm_mode) begin
                n_cmp_a = val_cw;
            end
        end
        if (i_ctrl.wr_cmp_b) begin
            n_pend_b = val_cw;
            if (!pwm_mode) begin
                n_cmp_b = val_cw;
            end
        end
        if (i_ctrl.wr_count) begin
            n_count = val_cw;
        end
        if (i_ctrl.clr_flags) begin
            n_flags = r_flags & ~i_value[2:0];
        end

        gated                  = n_levels & i_channel_enable;
        o_result.counter_now   = VALUE_W'(n_count);
        o_result.pwm_out_a     = gated[0];
        o_result.pwm_out_b     = gated[1];
        o_result.flag_match_a  = n_flags[FLAG_A];
        o_result.flag_match_b  = n_flags[FLAG_B];
        o_result.flag_overflow = n_flags[FLAG_OVF];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cmp_a  <= '0;
            r_cmp_b  <= '0;
            r_pend_a <= '0;
            r_pend_b <= '0;
            r_flags  <= '0;
            r_levels <= '0;
        end else begin
            r_count  <= n_count;
            r_cmp_a  <= n_cmp_a;
            r_cmp_b  <= n_cmp_b;
            r_pend_a <= n_pend_a;
            r_pend_b <= n_pend_b;
            r_flags  <= n_flags;
            r_levels <= n_levels;
        end
    end

endmodule
